>>> rtl/core/isd_pkg.sv
package isd_pkg;

    localparam int WINDOW_DEFAULT   = 100;
    localparam int CH_NUM           = 6;
    localparam int SAMPLE_W         = 16;
    localparam int SAMPLES_W        = CH_NUM * SAMPLE_W;
    localparam int THR_RAW_W        = 15;
    localparam int GYRO_THR_RESET   = 31;
    localparam int ACCEL_THR_RESET  = 51;
    localparam int GYRO_CH_NUM      = 3;
    localparam int CH_W             = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int OUT_DATA_W       = 8;

    localparam logic [CH_W-1:0]      NO_CHANNEL    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THR = 2'd1;

    // Per-stage control handed from the top level to a datapath stage
    typedef struct packed {
        logic load;
        logic decided;
    } isd_stage_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

>>> rtl/core/isd_ring.sv
module isd_ring
    import isd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT,
    localparam int ADDR_W = $clog2(WINDOW)
)
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [SAMPLES_W-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [SAMPLES_W-1:0] wr_data
);

    logic [SAMPLES_W-1:0] ring_reg [WINDOW];
    logic [SAMPLES_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ring_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/isd_accum.sv
module isd_accum
    import isd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT,
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW),
    localparam int DEV_W = SUM_W + 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  isd_stage_t              ctl,
    input  logic [SAMPLES_W-1:0]    sample,
    input  logic [SAMPLES_W-1:0]    oldest,
    output logic signed [DEV_W-1:0] dev [CH_NUM]
);

    logic signed [SUM_W-1:0] sum_reg  [CH_NUM];
    logic signed [SUM_W-1:0] sum_next [CH_NUM];
    logic signed [DEV_W-1:0] dev_reg  [CH_NUM];
    logic signed [DEV_W-1:0] dev_next [CH_NUM];

    // new*(W+1) - (sum+new) reduces to new*W - sum
    always_comb
    begin
        sample_t                 s_new;
        sample_t                 s_old;
        logic signed [DEV_W-1:0] total;
        logic signed [DEV_W-1:0] prod;
        for (int c = 0; c < CH_NUM; c++)
        begin
            s_new = sample[c*SAMPLE_W +: SAMPLE_W];
            s_old = oldest[c*SAMPLE_W +: SAMPLE_W];
            total = DEV_W'(sum_reg[c]) + DEV_W'(s_new);
            if (ctl.decided)
            begin
                total = total - DEV_W'(s_old);
            end
            sum_next[c] = total[SUM_W-1:0];
            prod        = DEV_W'(s_new) * DEV_W'(WINDOW);
            dev_next[c] = prod - DEV_W'(sum_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH_NUM; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (ctl.load)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dev_reg <= dev_next;
        end
    end

    assign dev = dev_reg;

endmodule

>>> rtl/core/isd_judge.sv
module isd_judge
    import isd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT,
    localparam int DEV_W = SAMPLE_W + $clog2(WINDOW) + 1,
    localparam int THR_W = THR_RAW_W + $clog2(WINDOW + 2),
    localparam int CMP_W = DEV_W + 1
)
(
    input  logic                    clk,
    input  isd_stage_t              ctl,
    input  logic signed [DEV_W-1:0] dev [CH_NUM],
    input  logic [THR_W-1:0]        gyro_thr,
    input  logic [THR_W-1:0]        accel_thr,
    output logic                    decided,
    output logic                    moving,
    output logic [CH_W-1:0]         first_channel
);

    logic            decided_reg;
    logic            moving_reg;
    logic [CH_W-1:0] first_reg;
    logic [CH_W-1:0] first_next;

    // Lowest exceeding channel wins; equality counts as still
    always_comb
    begin
        logic signed [CMP_W-1:0] d;
        logic signed [CMP_W-1:0] t;
        first_next = NO_CHANNEL;
        for (int c = CH_NUM - 1; c >= 0; c--)
        begin
            d = CMP_W'(dev[c]);
            t = (c < GYRO_CH_NUM) ? CMP_W'($signed({1'b0, gyro_thr}))
                                  : CMP_W'($signed({1'b0, accel_thr}));
            if (ctl.decided && ((d > t) || (d < -t)))
            begin
                first_next = CH_W'(c);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            decided_reg <= ctl.decided;
            moving_reg  <= (first_next != NO_CHANNEL);
            first_reg   <= first_next;
        end
    end

    assign decided       = decided_reg;
    assign moving        = moving_reg;
    assign first_channel = first_reg;

endmodule

>>> rtl/core/imu_stationarity_detector.sv
// IMU stationarity detector: moving-average zero-velocity test.
//
// Input stream (s_*): one transaction per six-channel sample, three gyro
// rates and three accelerations, signed Q5.10. Output stream (m_*): one
// transaction per input sample with decided, moving and first_channel.
// Config channel (cfg_*): index 0 gyro threshold, 1 accel threshold, low 15
// bits of cfg_data kept, other indexes dropped; always ready. Write it only
// while no sample is in flight.
//
// Throughput is one sample per cycle while the output is not stalled. The
// sample ring is a single-port-write, registered-read memory: one read of
// the oldest slot at acceptance and one write of the new sample as it
// leaves stage 1, so it sustains one sample per cycle.
// Per-channel running sums sit in flops beside it.
// The first WINDOW samples only fill the ring (decided = 0).
//
// Reset clears sums, fill count, ring pointer, pipeline valids and restores
// default thresholds; the ring itself is not cleared. When m_tready is low
// the pipeline fills its empty stages and then drops s_tready.
module imu_stationarity_detector
    import isd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, 16 bits each
    input  logic [SAMPLES_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // decided [0], moving [1], first_channel [4:2], zero pad [7:5]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int DEV_W  = SAMPLE_W + $clog2(WINDOW) + 1;
    localparam int THR_W  = THR_RAW_W + $clog2(WINDOW + 2);
    localparam int GYRO_THR_SCALED  = GYRO_THR_RESET * (WINDOW + 1);
    localparam int ACCEL_THR_SCALED = ACCEL_THR_RESET * (WINDOW + 1);

    // Thresholds are stored pre-scaled by WINDOW+1
    logic [THR_W-1:0] gyro_thr_reg;
    logic [THR_W-1:0] accel_thr_reg;
    logic [THR_W-1:0] thr_scaled;

    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              full;

    // Stage 1: sample plus ring read data; stage 2: deviations; then output
    logic                 s1_valid_reg;
    logic                 s1_decided_reg;
    logic [ADDR_W-1:0]    s1_slot_reg;
    logic [SAMPLES_W-1:0] s1_sample_reg;
    logic                 s2_valid_reg;
    logic                 s2_decided_reg;
    logic                 out_valid_reg;

    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic adv1;
    logic adv2;
    logic accept;

    logic [SAMPLES_W-1:0]    ring_rd_data;
    logic signed [DEV_W-1:0] dev [CH_NUM];
    isd_stage_t              acc_ctl;
    isd_stage_t              jdg_ctl;
    logic                    res_decided;
    logic                    res_moving;
    logic [CH_W-1:0]         res_first;

    // Handshake chain, drained from the output side
    assign out_ready = !out_valid_reg || m_tready;
    assign adv2      = s2_valid_reg && out_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign adv1      = s1_valid_reg && s2_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign accept    = s_tvalid && s1_ready;

    assign cfg_ready  = 1'b1;
    assign thr_scaled = THR_W'(cfg_data[THR_RAW_W-1:0]) * THR_W'(WINDOW + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_thr_reg  <= THR_W'(GYRO_THR_SCALED);
            accel_thr_reg <= THR_W'(ACCEL_THR_SCALED);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GYRO_THR:  gyro_thr_reg  <= thr_scaled;
                REG_ACCEL_THR: accel_thr_reg <= thr_scaled;
                default:       ;
            endcase
        end
    end

    // Ring pointer walks every slot; during fill it marks the next free slot,
    // once full it marks the oldest sample, which the new one replaces
    assign full      = (fill_reg == FILL_W'(WINDOW));
    assign ptr_next  = (ptr_reg == ADDR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    assign fill_next = full ? fill_reg : fill_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s1_decided_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_decided_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ptr_reg        <= ptr_next;
                fill_reg       <= fill_next;
                s1_decided_reg <= full;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv1)
            begin
                s2_decided_reg <= s1_decided_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg   <= ptr_reg;
            s1_sample_reg <= s_tdata;
        end
    end

    // Read the oldest slot at acceptance; write the new sample back as the
    // item leaves stage 1. Read and write slots differ since WINDOW >= 2.
    isd_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (ptr_reg),
        .rd_data (ring_rd_data),
        .wr_en   (adv1),
        .wr_addr (s1_slot_reg),
        .wr_data (s1_sample_reg)
    );

    assign acc_ctl.load    = adv1;
    assign acc_ctl.decided = s1_decided_reg;

    isd_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (acc_ctl),
        .sample (s1_sample_reg),
        .oldest (ring_rd_data),
        .dev    (dev)
    );

    assign jdg_ctl.load    = adv2;
    assign jdg_ctl.decided = s2_decided_reg;

    isd_judge #(
        .WINDOW (WINDOW)
    ) u_judge (
        .clk           (clk),
        .ctl           (jdg_ctl),
        .dev           (dev),
        .gyro_thr      (gyro_thr_reg),
        .accel_thr     (accel_thr_reg),
        .decided       (res_decided),
        .moving        (res_moving),
        .first_channel (res_first)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - CH_W - 2)'(0), res_first, res_moving, res_decided};

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill count past window");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= ADDR_W'(WINDOW - 1))
        else $error("ring pointer out of range");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_sample_reg)))
        else $error("stage 1 item lost under stall");

    a_decided_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_decided_reg) |-> full)
        else $error("decision taken before window filled");

    a_moving_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_moving == (res_first != NO_CHANNEL)))
        else $error("moving flag disagrees with first channel");
`endif

endmodule
